[src/nbhad_pkg.sv]
// nbhad_pkg: types and constants shared by the half-ascii name decoder
// no dependencies; imported by nbhad_apb, nbhad_core and the top level
`default_nettype none

package nbhad_pkg;

	// decoder phase
	typedef enum logic [1:0] {
		PH_LENGTH = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2,
		PH_ALIGN  = 2'd3
	} phase_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ODD      = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_BAD      = 2'd3
	} status_t;

	localparam int unsigned CNT_W    = 7;
	localparam logic [7:0]  LETTER_A = 8'h41;

	// register indexes
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic [CNT_W-1:0] MAX_LEN_RESET = 7'd16;

	// one result word
	typedef struct packed {
		logic [7:0]       data_byte;
		logic             has_data;
		logic             last;
		status_t          status;
		logic [CNT_W-1:0] name_count;
	} result_t;

endpackage

`default_nettype wire

[src/nbhad_apb.sv]
// nbhad_apb: apb register slave holding max_name_length
// depends on nbhad_pkg
`default_nettype none

module nbhad_apb (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output logic      [nbhad_pkg::CNT_W-1:0] max_len
);
	import nbhad_pkg::*;

	logic [CNT_W-1:0] max_len_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (wr_en) begin
			max_len_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_LEN) begin
			prdata[CNT_W-1:0] = max_len_q;
		end
	end

	assign max_len = max_len_q;

endmodule

`default_nettype wire

[src/nbhad_core.sv]
// nbhad_core: input register, phase machine and result register
// depends on nbhad_pkg
`default_nettype none

module nbhad_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [nbhad_pkg::CNT_W-1:0]   max_len,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output nbhad_pkg::result_t                 result
);
	import nbhad_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	result_t          result_q;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] pairs_left_q, pairs_left_d;
	logic [3:0]       high_nibble_q, high_nibble_d;
	logic             first_bad_q, first_bad_d;
	logic [CNT_W-1:0] produced_q, produced_d;

	logic             advance;
	logic [7:0]       off;
	logic             off_bad;
	logic [CNT_W-1:0] half;
	logic [CNT_W-1:0] pairs_dec;
	logic [CNT_W-1:0] produced_inc;
	logic             emit;
	result_t          res_d;

	function automatic logic [7:0] in_byte_s1_off(input logic [7:0] b);
		return b - LETTER_A;
	endfunction

	// s1 drains when the result slot is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign off          = in_byte_s1_off(byte_s1);
	assign off_bad      = (off[7:4] != 4'd0);
	assign half         = byte_s1[7:1];
	assign pairs_dec    = pairs_left_q - CNT_W'(1);
	assign produced_inc = produced_q + CNT_W'(1);

	// next state
	always_comb begin
		phase_d       = phase_q;
		pairs_left_d  = pairs_left_q;
		high_nibble_d = high_nibble_q;
		first_bad_d   = first_bad_q;
		produced_d    = produced_q;
		unique case (phase_q)
			PH_LENGTH: begin
				produced_d = '0;
				if (!byte_s1[0] && !(half > max_len)) begin
					pairs_left_d = half;
					phase_d      = (half == '0) ? PH_ALIGN : PH_FIRST;
				end
			end
			PH_FIRST: begin
				first_bad_d   = off_bad;
				high_nibble_d = off[3:0];
				phase_d       = PH_SECOND;
			end
			PH_SECOND: begin
				if (first_bad_q || off_bad) begin
					phase_d = PH_LENGTH;
				end else begin
					produced_d   = produced_inc;
					pairs_left_d = pairs_dec;
					phase_d      = (pairs_dec == '0) ? PH_ALIGN : PH_FIRST;
				end
			end
			PH_ALIGN: begin
				phase_d = PH_LENGTH;
			end
			default: begin
				phase_d = PH_LENGTH;
			end
		endcase
	end

	// result for the byte in s1
	always_comb begin
		emit              = 1'b0;
		res_d.data_byte   = '0;
		res_d.has_data    = 1'b0;
		res_d.last        = 1'b1;
		res_d.status      = ST_OK;
		res_d.name_count  = '0;
		unique case (phase_q)
			PH_LENGTH: begin
				if (byte_s1[0]) begin
					emit         = 1'b1;
					res_d.status = ST_ODD;
				end else if (half > max_len) begin
					emit         = 1'b1;
					res_d.status = ST_TOO_LONG;
				end else if (half == '0) begin
					emit = 1'b1;
				end
			end
			PH_SECOND: begin
				emit = 1'b1;
				if (first_bad_q || off_bad) begin
					res_d.status     = ST_BAD;
					res_d.name_count = produced_q;
				end else begin
					res_d.data_byte  = {high_nibble_q, off[3:0]};
					res_d.has_data   = 1'b1;
					res_d.last       = (pairs_dec == '0);
					res_d.name_count = produced_inc;
				end
			end
			PH_FIRST, PH_ALIGN: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			phase_q       <= PH_LENGTH;
			pairs_left_q  <= '0;
			high_nibble_q <= '0;
			first_bad_q   <= 1'b0;
			produced_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q       <= phase_d;
				pairs_left_q  <= pairs_left_d;
				high_nibble_q <= high_nibble_d;
				first_bad_q   <= first_bad_d;
				produced_q    <= produced_d;
			end
			if (advance) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
		if (advance && emit) begin
			result_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

[src/netbios_half_ascii_name_decoder.sv]
// netbios_half_ascii_name_decoder: top level of the half-ascii name decoder
// depends on nbhad_pkg, nbhad_apb and nbhad_core
`default_nettype none

// channel   | direction | handshake             | word
// ----------+-----------+-----------------------+------------------------------------------
// input     | in        | in_valid / in_ready   | in_byte
// result    | out       | out_valid / out_ready | data_byte, has_data, last, status, name_count
// config    | in        | apb psel/penable      | max_name_length at byte address 0
//
// one byte per cycle sustained while results are taken; an accepted byte passes the input register,
// then the phase machine into the result register
// bytes that give no result (first letter, alignment, length of a non-empty name)
// still pass through the phase machine and leave nothing on the output
// reset clears the phase machine to wait for a length byte and max_name_length to 16
// a stalled result holds the result register and the byte in the input register;
// out_ready reaches in_ready combinationally, so a full input register stops
// accepting in the same cycle, an empty one still takes one more byte

module netbios_half_ascii_name_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// encoded byte stream
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	// decoded results
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  data_byte,
	output logic             has_data,
	output logic             last,
	output logic      [1:0]  status,
	output logic      [nbhad_pkg::CNT_W-1:0] name_count
);
	import nbhad_pkg::*;

	logic [CNT_W-1:0] max_len;
	result_t          result;

	// register slave
	nbhad_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_len (max_len)
	);

	// byte pipeline and phase machine
	nbhad_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_len   (max_len),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	// unpack the result word onto its ports
	assign data_byte  = result.data_byte;
	assign has_data   = result.has_data;
	assign last       = result.last;
	assign status     = result.status;
	assign name_count = result.name_count;

endmodule

`default_nettype wire
